// ===== design/fraction_reduce_and_compare_top_assert.svh =====
// assertion macros for the fraction reduce and compare block
// each macro samples on clk_i and is disabled while rst_ni is low
`ifndef FRACTION_REDUCE_AND_COMPARE_TOP_ASSERT_SVH
`define FRACTION_REDUCE_AND_COMPARE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define FRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define FRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FRC_ASSERT_IMP(lbl, ante, cons, msg)

`define FRC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/frc_pkg.sv =====
package frc_pkg;

  // working width of each value, signed, and as wide as one port field
  localparam int VALUE_WIDTH = 32;
  localparam int FRC_MAG_W   = VALUE_WIDTH - 1;
  localparam int FRC_SHIFT_W = $clog2(FRC_MAG_W);
  localparam int FRC_CNT_W   = $clog2(FRC_MAG_W);
  localparam int FRC_PROD_W  = 2 * VALUE_WIDTH;

  // port field widths
  localparam int FRC_FIELD_W = 32;
  localparam int FRC_UNS_W   = 31;
  localparam int FRC_REL_W   = 2;
  localparam int FRC_IN_W    = 4 * FRC_FIELD_W;

  // relation codes
  localparam logic [FRC_REL_W-1:0] REL_LESS    = 2'd0;
  localparam logic [FRC_REL_W-1:0] REL_EQUAL   = 2'd1;
  localparam logic [FRC_REL_W-1:0] REL_GREATER = 2'd2;

  // reduced fraction with its mixed-number split
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] num;
    logic [FRC_MAG_W-1:0]          den;
    logic [FRC_MAG_W-1:0]          whole;
    logic [FRC_MAG_W-1:0]          rem;
  } frc_frac_t;

endpackage

// ===== design/fraction_reduce_and_compare_top.sv =====
// fraction reduce and compare: one result transaction per input transaction
// each transaction passes the input registers, both lanes (binary gcd loop, then three serial divisions),
//   the merge (cross products, then compare) and the output register, in that order
// one item at a time: the next transaction is taken only after the result is parked in the output register
// a zero denominator skips the lanes and the merge, the result is parked with zero data and bad_input set
// rst_ni is asynchronous and active low, it clears all handshake and sequencing state
`include "fraction_reduce_and_compare_top_assert.svh"

module fraction_reduce_and_compare_top import frc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // s_axis_tdata_i: first_num, first_den, second_num, second_den (32 bits each)
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [FRC_IN_W-1:0] s_axis_tdata_i,
  // m_axis_tdata_o: first_red_num, first_red_den, second_red_num, second_red_den,
  //   first_whole, first_rem, second_whole, second_rem, relation, zero fill
  // m_axis_tuser_o: bad_input
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [255:0]        m_axis_tdata_o,
  output logic                m_axis_tuser_o
);

  // output field offsets
  localparam int O_FRN = 0;
  localparam int O_FRD = O_FRN + FRC_FIELD_W;
  localparam int O_SRN = O_FRD + FRC_UNS_W;
  localparam int O_SRD = O_SRN + FRC_FIELD_W;
  localparam int O_FW  = O_SRD + FRC_UNS_W;
  localparam int O_FR  = O_FW + FRC_UNS_W;
  localparam int O_SW  = O_FR + FRC_UNS_W;
  localparam int O_SR  = O_SW + FRC_UNS_W;
  localparam int O_REL = O_SR + FRC_UNS_W;

  // sequencing states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LANE  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]           state_q;
  logic                 lane_go_q;
  logic                 merge_go_q;
  logic [1:0]           lane_seen_q;
  logic                 bad_q;
  logic                 out_vld_q;
  logic [255:0]         out_data_q;
  logic                 out_user_q;
  logic [255:0]         out_next;
  logic [FRC_REL_W-1:0] rel_q;

  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] n1, d1, n2, d2;
  logic [VALUE_WIDTH-1:0] n1_q, d1_q, n2_q, d2_q;
  logic                   den_zero;
  logic [1:0]             lane_done;
  frc_frac_t              f1, f2;
  logic                   lanes_all;
  logic                   merge_done;
  logic [FRC_REL_W-1:0]   merge_rel;
  logic                   push_ok;

  // each value is taken whole from its field
  assign n1 = s_axis_tdata_i[0*FRC_FIELD_W +: VALUE_WIDTH];
  assign d1 = s_axis_tdata_i[1*FRC_FIELD_W +: VALUE_WIDTH];
  assign n2 = s_axis_tdata_i[2*FRC_FIELD_W +: VALUE_WIDTH];
  assign d2 = s_axis_tdata_i[3*FRC_FIELD_W +: VALUE_WIDTH];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign den_zero        = (d1 == '0) || (d2 == '0);

  // one lane per fraction
  frc_lane u_lane0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_go_q),
    .num_i   (n1_q),
    .den_i   (d1_q),
    .done_o  (lane_done[0]),
    .res_o   (f1)
  );

  frc_lane u_lane1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lane_go_q),
    .num_i   (n2_q),
    .den_i   (d2_q),
    .done_o  (lane_done[1]),
    .res_o   (f2)
  );

  // lanes finish at different times, wait for both
  assign lanes_all = (lane_seen_q[0] || lane_done[0]) && (lane_seen_q[1] || lane_done[1]);

  frc_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (merge_go_q),
    .f1_i       (f1),
    .f2_i       (f2),
    .done_o     (merge_done),
    .relation_o (merge_rel)
  );

  // output register frees the core as soon as the result is parked
  assign push_ok = !out_vld_q || m_axis_tready_i;

  always_comb begin
    out_next = '0;
    if (!bad_q) begin
      out_next[O_FRN +: FRC_FIELD_W] = FRC_FIELD_W'(f1.num);
      out_next[O_FRD +: FRC_UNS_W]   = FRC_UNS_W'(f1.den);
      out_next[O_SRN +: FRC_FIELD_W] = FRC_FIELD_W'(f2.num);
      out_next[O_SRD +: FRC_UNS_W]   = FRC_UNS_W'(f2.den);
      out_next[O_FW  +: FRC_UNS_W]   = FRC_UNS_W'(f1.whole);
      out_next[O_FR  +: FRC_UNS_W]   = FRC_UNS_W'(f1.rem);
      out_next[O_SW  +: FRC_UNS_W]   = FRC_UNS_W'(f2.whole);
      out_next[O_SR  +: FRC_UNS_W]   = FRC_UNS_W'(f2.rem);
      out_next[O_REL +: FRC_REL_W]   = rel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_go_q   <= 1'b0;
      merge_go_q  <= 1'b0;
      lane_seen_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      lane_go_q  <= in_fire && !den_zero;
      merge_go_q <= (state_q == ST_LANE) && lanes_all;
      // set when a result is parked, cleared when the receiver takes it
      out_vld_q  <= ((state_q == ST_PUSH) && push_ok) || (out_vld_q && !m_axis_tready_i);
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            lane_seen_q <= '0;
            if (den_zero) begin
              state_q <= ST_PUSH;
            end else begin
              state_q <= ST_LANE;
            end
          end
        end
        ST_LANE: begin
          lane_seen_q <= lane_seen_q | lane_done;
          if (lanes_all) state_q <= ST_MERGE;
        end
        ST_MERGE: begin
          if (merge_done) state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_ok) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      n1_q  <= n1;
      d1_q  <= d1;
      n2_q  <= n2;
      d2_q  <= d2;
      bad_q <= den_zero;
    end
    if (merge_done) rel_q <= merge_rel;
    if (state_q == ST_PUSH && push_ok) begin
      out_data_q <= out_next;
      out_user_q <= bad_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `FRC_ASSERT_IMP(a_lane_done_in_run, lane_done[0] || lane_done[1], state_q == ST_LANE,
                  "lane finished outside the run phase")
  `FRC_ASSERT_NXT(a_busy_after_accept, in_fire, state_q != ST_IDLE,
                  "core still idle after an accepted transaction")
  `FRC_ASSERT_IMP(a_bad_all_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0,
                  "error result carries nonzero data")
  `FRC_ASSERT_IMP(a_rem_below_den, m_axis_tvalid_o && !m_axis_tuser_o,
                  (m_axis_tdata_o[O_FR +: FRC_UNS_W] < m_axis_tdata_o[O_FRD +: FRC_UNS_W]) &&
                  (m_axis_tdata_o[O_SR +: FRC_UNS_W] < m_axis_tdata_o[O_SRD +: FRC_UNS_W]),
                  "remainder not below reduced denominator")
  `FRC_ASSERT_IMP(a_rel_code, m_axis_tvalid_o, m_axis_tdata_o[O_REL +: FRC_REL_W] <= REL_GREATER,
                  "relation code out of range")

endmodule

// ===== design/frc_div.sv =====
module frc_div import frc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FRC_MAG_W-1:0] dividend_i,
  input  logic [FRC_MAG_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [FRC_MAG_W-1:0] quot_o,
  output logic [FRC_MAG_W-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [FRC_CNT_W-1:0] cnt_q, cnt_d;
  logic [FRC_MAG_W-1:0] quot_q, quot_d;
  logic [FRC_MAG_W-1:0] rem_q, rem_d;
  logic [FRC_MAG_W-1:0] div_q, div_d;
  logic [FRC_MAG_W:0]   trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial  = {rem_q, quot_q[FRC_MAG_W-1]};
    fits   = trial >= {1'b0, div_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[FRC_MAG_W-2:0], fits};
      rem_d  = fits ? FRC_MAG_W'(trial - {1'b0, div_q}) : trial[FRC_MAG_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == FRC_CNT_W'(FRC_MAG_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/frc_lane.sv =====
module frc_lane import frc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] num_i,
  input  logic [VALUE_WIDTH-1:0] den_i,
  output logic                   done_o,
  output frc_frac_t              res_o
);

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_GCD  = 3'd1;
  localparam logic [2:0] L_DIVN = 3'd2;
  localparam logic [2:0] L_DIVD = 3'd3;
  localparam logic [2:0] L_DIVW = 3'd4;

  localparam logic [VALUE_WIDTH-1:0] MOST_NEG = {1'b1, {FRC_MAG_W{1'b0}}};

  logic [2:0]             state_q;
  logic                   div_go_q;
  logic                   done_q;
  logic [FRC_MAG_W-1:0]   a_q, b_q, a_d, b_d;
  logic [FRC_SHIFT_W-1:0] k_q, k_d;
  logic [FRC_MAG_W-1:0]   num_mag_q, den_mag_q, g_q, an_q, ad_q, whole_q, rem_q;
  logic                   neg_q;
  logic [FRC_MAG_W-1:0]   num_mag, den_mag;
  logic [VALUE_WIDTH-1:0] num_neg, den_neg;
  logic                   gcd_fin;
  logic [FRC_MAG_W-1:0]   g_base, g_next;
  logic [FRC_MAG_W-1:0]   div_a, div_b;
  logic                   div_done;
  logic [FRC_MAG_W-1:0]   div_quot, div_rem;
  logic [VALUE_WIDTH-1:0] an_ext;

  // magnitudes, the most negative code saturates to the largest magnitude
  assign num_neg = ~num_i + 1'b1;
  assign den_neg = ~den_i + 1'b1;
  assign num_mag = (num_i == MOST_NEG) ? {FRC_MAG_W{1'b1}} :
                   num_i[VALUE_WIDTH-1] ? num_neg[FRC_MAG_W-1:0] : num_i[FRC_MAG_W-1:0];
  assign den_mag = (den_i == MOST_NEG) ? {FRC_MAG_W{1'b1}} :
                   den_i[VALUE_WIDTH-1] ? den_neg[FRC_MAG_W-1:0] : den_i[FRC_MAG_W-1:0];

  // binary gcd step: strip common twos, halve a lone even value, else subtract odd from odd and halve
  always_comb begin
    gcd_fin = (a_q == '0) || (b_q == '0);
    g_base  = (a_q == '0) ? b_q : a_q;
    g_next  = g_base << k_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + 1'b1;
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q >= b_q) begin
      a_d = (a_q - b_q) >> 1;
    end else begin
      b_d = (b_q - a_q) >> 1;
    end
  end

  always_comb begin
    case (state_q)
      L_DIVN: begin
        div_a = num_mag_q;
        div_b = g_q;
      end
      L_DIVD: begin
        div_a = den_mag_q;
        div_b = g_q;
      end
      L_DIVW: begin
        div_a = an_q;
        div_b = ad_q;
      end
      default: begin
        div_a = an_q;
        div_b = ad_q;
      end
    endcase
  end

  frc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      div_go_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      div_go_q <= ((state_q == L_GCD) && gcd_fin) ||
                  ((state_q inside {L_DIVN, L_DIVD}) && div_done);
      done_q   <= (state_q == L_DIVW) && div_done;
      case (state_q)
        L_IDLE: begin
          if (start_i) state_q <= L_GCD;
        end
        L_GCD: begin
          if (gcd_fin) state_q <= L_DIVN;
        end
        L_DIVN: begin
          if (div_done) state_q <= L_DIVD;
        end
        L_DIVD: begin
          if (div_done) state_q <= L_DIVW;
        end
        L_DIVW: begin
          if (div_done) state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q       <= num_mag;
      b_q       <= den_mag;
      k_q       <= '0;
      num_mag_q <= num_mag;
      den_mag_q <= den_mag;
      neg_q     <= num_i[VALUE_WIDTH-1] ^ den_i[VALUE_WIDTH-1];
    end else begin
      case (state_q)
        L_GCD: begin
          if (gcd_fin) begin
            g_q <= g_next;
          end else begin
            a_q <= a_d;
            b_q <= b_d;
            k_q <= k_d;
          end
        end
        L_DIVN: if (div_done) an_q <= div_quot;
        L_DIVD: if (div_done) ad_q <= div_quot;
        L_DIVW: begin
          if (div_done) begin
            whole_q <= div_quot;
            rem_q   <= div_rem;
          end
        end
        default: ;
      endcase
    end
  end

  assign an_ext      = {1'b0, an_q};
  assign done_o      = done_q;
  assign res_o.num   = neg_q ? $signed(~an_ext + 1'b1) : $signed(an_ext);
  assign res_o.den   = ad_q;
  assign res_o.whole = whole_q;
  assign res_o.rem   = rem_q;

endmodule

// ===== design/frc_merge.sv =====
module frc_merge import frc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  frc_frac_t            f1_i,
  input  frc_frac_t            f2_i,
  output logic                 done_o,
  output logic [FRC_REL_W-1:0] relation_o
);

  logic                         prod_vld_q;
  logic                         done_q;
  logic signed [FRC_PROD_W-1:0] lhs_q, rhs_q;
  logic [FRC_REL_W-1:0]         rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      prod_vld_q <= start_i;
      done_q     <= prod_vld_q;
    end
  end

  // cross products into lhs_q and rhs_q, then the compare into rel_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lhs_q <= f1_i.num * $signed({1'b0, f2_i.den});
      rhs_q <= f2_i.num * $signed({1'b0, f1_i.den});
    end
    if (prod_vld_q) begin
      if (lhs_q < rhs_q) rel_q <= REL_LESS;
      else if (lhs_q == rhs_q) rel_q <= REL_EQUAL;
      else rel_q <= REL_GREATER;
    end
  end

  assign done_o     = done_q;
  assign relation_o = rel_q;

endmodule
